[rtl/jse_pkg.sv]
// Shared types, character codes and helpers for the JSON string escaper.
// No dependencies; every other file of the block imports this package.
package jse_pkg;

  // Character codes used in escaped output
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;

  // Raw control bytes with a short escape
  localparam logic [7:0] RAW_BS  = 8'h08;
  localparam logic [7:0] RAW_TAB = 8'h09;
  localparam logic [7:0] RAW_LF  = 8'h0A;
  localparam logic [7:0] RAW_FF  = 8'h0C;
  localparam logic [7:0] RAW_CR  = 8'h0D;

  // Bytes below this limit need an escape
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Body lengths per escape kind
  localparam logic [3:0] LEN_PLAIN = 4'd1;
  localparam logic [3:0] LEN_SHORT = 4'd2;
  localparam logic [3:0] LEN_UNI   = 4'd6;

  // How the body byte of an item is rendered
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNI
  } jse_kind_t;

  // Input item
  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       string_start;
    logic       string_end;
  } jse_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } jse_out_t;

  // Classified work for the emitter
  typedef struct packed {
    logic       open_q;
    logic       close_q;
    jse_kind_t  kind;
    logic [7:0] value;   // plain byte, short-escape letter or raw control byte
    logic [3:0] count;   // total output bytes, 0..8
  } jse_desc_t;

  // Lower-case hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      hex_digit = CH_ZERO + {4'd0, v};
    end else begin
      hex_digit = CH_LOWER_A + {4'd0, v - 4'd10};
    end
  endfunction

endpackage

[rtl/jse_classify.sv]
// Front end: classifies one input item into an escape descriptor.
// Depends on jse_pkg.
module jse_classify
  import jse_pkg::*;
(
  input  jse_in_t   item,
  output jse_desc_t desc,
  output logic      has_output
);

  logic [7:0] letter;
  logic [3:0] body_len;

  // Pick the short escape letter, if any
  always_comb begin
    case (item.byte_value)
      CH_QUOTE:  letter = CH_QUOTE;
      CH_BSLASH: letter = CH_BSLASH;
      RAW_BS:    letter = CH_B;
      RAW_FF:    letter = CH_F;
      RAW_LF:    letter = CH_N;
      RAW_CR:    letter = CH_R;
      RAW_TAB:   letter = CH_T;
      default:   letter = 8'h00;
    endcase
  end

  // Classify the body and count the output bytes
  always_comb begin
    desc.open_q  = item.string_start;
    desc.close_q = item.string_end;
    desc.value   = item.byte_value;
    desc.kind    = KIND_NONE;
    body_len     = 4'd0;
    if (item.byte_present) begin
      if (letter != 8'h00) begin
        desc.kind  = KIND_SHORT;
        desc.value = letter;
        body_len   = LEN_SHORT;
      end else if (item.byte_value < CTRL_LIMIT) begin
        desc.kind = KIND_UNI;
        body_len  = LEN_UNI;
      end else begin
        desc.kind = KIND_PLAIN;
        body_len  = LEN_PLAIN;
      end
    end
    desc.count = body_len + {3'd0, item.string_start} + {3'd0, item.string_end};
    has_output = (desc.count != 4'd0);
  end

endmodule

[rtl/jse_queue.sv]
// Short descriptor queue between the classifier and the emitter.
// Depends on jse_pkg.
module jse_queue
  import jse_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  jse_desc_t push_desc,
  input  logic      pop,
  output jse_desc_t head,
  output logic      head_valid,
  output logic      full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jse_desc_t       slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed descriptor
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head       = slots_r[rd_ptr_r];
  assign head_valid = (fill_r != '0);
  assign full       = (fill_r == CW'(DEPTH));

endmodule

[rtl/jse_emit.sv]
// Back end: walks the head descriptor and sends one output byte per cycle while the queue holds one.
// Depends on jse_pkg.
module jse_emit
  import jse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  jse_desc_t head,
  input  logic      head_valid,
  output logic      pop,
  output jse_out_t  out_item,
  output logic      out_valid
);

  logic [2:0] index_r, index_nxt;
  logic [2:0] body_pos;
  logic       is_last;
  logic [7:0] body_byte;
  logic [7:0] cur_byte;
  logic       out_valid_r;
  jse_out_t   out_item_r;

  assign is_last  = ({1'b0, index_r} + 4'd1) == head.count;
  assign pop      = head_valid && is_last;
  assign body_pos = index_r - {2'd0, head.open_q};

  // Render the body byte at the current position
  always_comb begin
    case (head.kind)
      KIND_PLAIN: body_byte = head.value;
      KIND_SHORT: body_byte = (body_pos == 3'd0) ? CH_BSLASH : head.value;
      KIND_UNI: begin
        case (body_pos)
          3'd0:    body_byte = CH_BSLASH;
          3'd1:    body_byte = CH_U;
          3'd2:    body_byte = CH_ZERO;
          3'd3:    body_byte = CH_ZERO;
          3'd4:    body_byte = hex_digit(head.value[7:4]);
          default: body_byte = hex_digit(head.value[3:0]);
        endcase
      end
      default:    body_byte = CH_QUOTE;
    endcase
  end

  // Quotes frame the body
  always_comb begin
    if (head.open_q && index_r == 3'd0) begin
      cur_byte = CH_QUOTE;
    end else if (head.close_q && is_last) begin
      cur_byte = CH_QUOTE;
    end else begin
      cur_byte = body_byte;
    end
  end

  // Step through the bytes, restart on the next descriptor
  always_comb begin
    index_nxt = index_r;
    if (head_valid) begin
      index_nxt = is_last ? 3'd0 : index_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      index_r     <= index_nxt;
      out_valid_r <= head_valid;
    end
  end

  // Register the result payload
  always_ff @(posedge clk) begin
    out_item_r.out_byte <= cur_byte;
    out_item_r.run_last <= is_last;
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule

[rtl/json_string_escaper_core.sv]
// Top level of the JSON string escaper: classifier, descriptor queue, emitter.
// Depends on jse_pkg, jse_classify, jse_queue and jse_emit.
//
// Usage:
//   Input: drive in_item and raise start; the item is taken at a clock edge
//   where start is high and busy is low. busy is high while the descriptor
//   queue (QUEUE_DEPTH entries) is full.
//   Output: each escaped byte shows on out_item for one cycle with out_valid
//   high; run_last marks the last byte of an item. Items with no byte and no
//   quote flags produce nothing.
//   Path: a taken item is written to a queue slot, and each of its bytes
//   is then registered onto out_item once the queue holds no earlier work.
//   Throughput: one byte per cycle while the queue holds work; an item
//   occupies the emitter until all its bytes are sent (1 for a plain byte,
//   up to 8 for a framed \u escape). Plain bytes sustain one item per cycle.
//   Reset: synchronous, active low; empties the queue and drops any partly
//   sent item. The receiver cannot stall the output.
module json_string_escaper_core
  import jse_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  jse_in_t  in_item,
  output logic     out_valid,
  output jse_out_t out_item
);

  jse_desc_t cls_desc;
  logic      cls_has_output;
  jse_desc_t head;
  logic      head_valid;
  logic      pop;
  logic      full;
  logic      push;

  // Classify the offered item
  jse_classify u_classify (
    .item       (in_item),
    .desc       (cls_desc),
    .has_output (cls_has_output)
  );

  // Queue items that produce output
  assign push = start && !busy && cls_has_output;
  assign busy = full;

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (cls_desc),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  // Emit escaped bytes
  jse_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_item   (out_item),
    .out_valid  (out_valid)
  );

endmodule

[rtl/jse_checker.sv]
// Port-level checks for json_string_escaper_core, bound to the top level.
// Depends on jse_pkg.
module jse_checker
  import jse_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input jse_out_t out_item
);

  // Reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // Reset empties the queue
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy high right after reset");

  // The queue fills only through an accepted item
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  // Bytes of one item leave in consecutive cycles
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.run_last |=> out_valid)
    else $error("gap inside an item's output run");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[sim/tb_json_string_escaper_core.sv]
// Self-checking testbench for json_string_escaper_core: directed table, then random items.
// Depends on jse_pkg and the block's RTL; expected text is typed or from an in-bench escaper.
module tb_json_string_escaper_core
  import jse_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int N_DIRECTED    = 24;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int PREDICT       = -1;

  // One directed row: the item, and its typed-in text (left-aligned) or PREDICT
  typedef struct packed {
    jse_in_t     item;
    int          len;
    logic [63:0] text;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  jse_in_t  in_item;
  logic     out_valid;
  jse_out_t out_item;

  // Expectation source for the item on the inputs, set with in_item
  int          typed_len;
  logic [63:0] typed_text;

  jse_out_t expected_bytes[$];
  int       error_count;
  int       items_taken;
  int       bytes_seen;
  int       cycle_count;
  int       sender_idle_pct;
  int       phase_idle_pct[4] = '{0, 53, 0, 12};

  dir_row_t directed_rows[N_DIRECTED] = '{
    '{'{8'h00, 1'b0, 1'b1, 1'b1}, 2, 64'h2222_0000_0000_0000},
    '{'{8'hA5, 1'b0, 1'b0, 1'b0}, 0, 64'h0},
    '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1, 64'h2200_0000_0000_0000},
    '{'{8'hFF, 1'b0, 1'b0, 1'b1}, 1, 64'h2200_0000_0000_0000},
    '{'{8'h00, 1'b1, 1'b0, 1'b0}, 6, 64'h5C75_3030_3030_0000},
    '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1, 64'hFF00_0000_0000_0000},
    '{'{8'h00, 1'b1, 1'b1, 1'b1}, 8, 64'h225C_7530_3030_3022},
    '{'{8'hFF, 1'b1, 1'b1, 1'b1}, 3, 64'h22FF_2200_0000_0000},
    '{'{8'h1F, 1'b1, 1'b0, 1'b0}, 6, 64'h5C75_3030_3166_0000},
    '{'{8'h22, 1'b1, 1'b0, 1'b0}, PREDICT, 64'h0},
    '{'{8'h5C, 1'b1, 1'b0, 1'b0}, PREDICT, 64'h0},
    '{'{8'h08, 1'b1, 1'b1, 1'b0}, PREDICT, 64'h0},
    '{'{8'h0C, 1'b1, 1'b0, 1'b1}, PREDICT, 64'h0},
    '{'{8'h0A, 1'b1, 1'b0, 1'b0}, PREDICT, 64'h0},
    '{'{8'h0D, 1'b1, 1'b1, 1'b1}, PREDICT, 64'h0},
    '{'{8'h09, 1'b1, 1'b0, 1'b0}, PREDICT, 64'h0},
    '{'{8'h0B, 1'b1, 1'b0, 1'b0}, PREDICT, 64'h0},
    '{'{8'h1B, 1'b1, 1'b1, 1'b0}, PREDICT, 64'h0},
    '{'{8'h20, 1'b1, 1'b0, 1'b0}, PREDICT, 64'h0},
    '{'{8'h7F, 1'b1, 1'b0, 1'b1}, PREDICT, 64'h0},
    '{'{8'h80, 1'b1, 1'b0, 1'b0}, PREDICT, 64'h0},
    '{'{8'h41, 1'b1, 1'b1, 1'b0}, PREDICT, 64'h0},
    '{'{8'h5C, 1'b1, 1'b1, 1'b1}, PREDICT, 64'h0},
    '{'{8'h5A, 1'b0, 1'b0, 1'b0}, PREDICT, 64'h0}
  };

  json_string_escaper_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Lower-case hex character of a nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return CH_LOWER_A + {4'd0, nib} - 8'd10;
  endfunction

  // Escape one item into JSON text and queue its bytes
  function automatic void push_escaped(input jse_in_t it);
    logic [7:0] text[0:7];
    logic [7:0] letter;
    jse_out_t   e;
    int         n;
    n = 0;
    if (it.string_start) begin
      text[n] = CH_QUOTE;
      n++;
    end
    if (it.byte_present) begin
      case (it.byte_value)
        CH_QUOTE:  letter = CH_QUOTE;
        CH_BSLASH: letter = CH_BSLASH;
        RAW_BS:    letter = CH_B;
        RAW_FF:    letter = CH_F;
        RAW_LF:    letter = CH_N;
        RAW_CR:    letter = CH_R;
        RAW_TAB:   letter = CH_T;
        default:   letter = 8'h00;
      endcase
      if (letter != 8'h00) begin
        text[n]     = CH_BSLASH;
        text[n + 1] = letter;
        n += 2;
      end else if (it.byte_value < CTRL_LIMIT) begin
        text[n]     = CH_BSLASH;
        text[n + 1] = CH_U;
        text[n + 2] = CH_ZERO;
        text[n + 3] = CH_ZERO;
        text[n + 4] = nibble_char(it.byte_value[7:4]);
        text[n + 5] = nibble_char(it.byte_value[3:0]);
        n += 6;
      end else begin
        text[n] = it.byte_value;
        n++;
      end
    end
    if (it.string_end) begin
      text[n] = CH_QUOTE;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      e.out_byte = text[i];
      e.run_last = (i == n - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  // Random raw byte, weighted toward escapes, high bytes and framing
  function automatic jse_in_t random_raw_item();
    jse_in_t it;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.byte_value = 8'($urandom_range(31));
    end else if (pick < 32) begin
      it.byte_value = $urandom_range(1) ? CH_QUOTE : CH_BSLASH;
    end else if (pick < 42) begin
      it.byte_value = 8'($urandom_range(255, 127));
    end else if (pick < 72) begin
      it.byte_value = 8'($urandom_range(126, 32));
    end else begin
      it.byte_value = 8'($urandom_range(255));
    end
    it.byte_present = ($urandom_range(99) < 88);
    it.string_start = ($urandom_range(99) < 20);
    it.string_end   = ($urandom_range(99) < 20);
    return it;
  endfunction

  // Present one item after a random idle gap; return once it is taken
  task automatic send_item(input jse_in_t it, input int len, input logic [63:0] text);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= random_raw_item();
    end
    @(negedge clk);
    start      <= 1'b1;
    in_item    <= it;
    typed_len  <= len;
    typed_text <= text;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Check each output byte against the oldest expectation; queue text for taken items
  always @(posedge clk) begin
    jse_out_t e;
    if (rst_n) begin
      if (out_valid) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected output byte %h (run_last %b)", out_item.out_byte,
                 out_item.run_last);
          error_count++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_item.out_byte !== e.out_byte) begin
            $error("out_byte: expected %h, got %h", e.out_byte, out_item.out_byte);
            error_count++;
          end
          if (out_item.run_last !== e.run_last) begin
            $error("run_last: expected %b, got %b", e.run_last, out_item.run_last);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        items_taken++;
        if (typed_len == PREDICT) begin
          push_escaped(in_item);
        end else begin
          for (int i = 0; i < typed_len; i++) begin
            e.out_byte = typed_text[63 - 8 * i -: 8];
            e.run_last = (i == typed_len - 1);
            expected_bytes.push_back(e);
          end
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("json_string_escaper_core verification failed");
      $finish;
    end
  end

  initial begin
    error_count     = 0;
    items_taken     = 0;
    bytes_seen      = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    typed_len       = PREDICT;
    typed_text      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: framing, extremes and each escape kind
    sender_idle_pct = 12;
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_item(directed_rows[r].item, directed_rows[r].len, directed_rows[r].text);
    end

    // Random: one block per idling phase
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = phase_idle_pct[ph];
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Hold off once until the block has drained
        if (ph == 1 && k == ITEMS_PER_PHASE / 2) begin
          @(negedge clk);
          start <= 1'b0;
          while (expected_bytes.size() != 0) @(negedge clk);
        end
        send_item(random_raw_item(), PREDICT, 64'h0);
      end
    end

    // Drain, then wait for stray bytes
    @(negedge clk);
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Escaped %0d items (%0d from the directed table) into %0d output bytes,",
             items_taken, N_DIRECTED, bytes_seen);
    $display("over four sender idling phases and one full drain; %0d errors", error_count);
    if (error_count == 0) begin
      $display("json_string_escaper_core verification clean");
    end else begin
      $display("json_string_escaper_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/jse_pkg.sv
rtl/jse_classify.sv
rtl/jse_queue.sv
rtl/jse_emit.sv
rtl/json_string_escaper_core.sv
rtl/jse_checker.sv
sim/tb_json_string_escaper_core.sv
